// ===== rtl/core/bjsd_pkg.sv =====
// shared types and codes for the binary json scalar decoder
package bjsd_pkg;

  // result kinds
  localparam logic [2:0] KIND_NULL   = 3'd0;
  localparam logic [2:0] KIND_TRUE   = 3'd1;
  localparam logic [2:0] KIND_FALSE  = 3'd2;
  localparam logic [2:0] KIND_SINT   = 3'd3;
  localparam logic [2:0] KIND_UINT   = 3'd4;
  localparam logic [2:0] KIND_DOUBLE = 3'd5;
  localparam logic [2:0] KIND_STRING = 3'd6;
  localparam logic [2:0] KIND_ERROR  = 3'd7;

  // type codes of the leading byte
  localparam logic [3:0] TC_LITERAL = 4'h4;
  localparam logic [3:0] TC_INT16   = 4'h5;
  localparam logic [3:0] TC_UINT16  = 4'h6;
  localparam logic [3:0] TC_INT32   = 4'h7;
  localparam logic [3:0] TC_UINT32  = 4'h8;
  localparam logic [3:0] TC_INT64   = 4'h9;
  localparam logic [3:0] TC_UINT64  = 4'hA;
  localparam logic [3:0] TC_DOUBLE  = 4'hB;
  localparam logic [3:0] TC_STRING  = 4'hC;

  localparam logic [7:0] LIT_NULL  = 8'h00;
  localparam logic [7:0] LIT_FALSE = 8'h02;

  localparam int unsigned PREFIX_MAX_BYTES = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  value_kind;
    logic [63:0] value_bits;
    logic [31:0] string_length;
    logic [2:0]  string_offset;
  } result_t;

endpackage

// ===== rtl/core/bjsd_if.sv =====
// valid/ready channel interfaces for input bytes and decoded results
interface bjsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface bjsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  value_kind;
  logic [63:0] value_bits;
  logic [31:0] string_length;
  logic [2:0]  string_offset;

  modport source (output valid, value_kind, value_bits, string_length, string_offset,
                  input ready);
  modport sink   (input valid, value_kind, value_bits, string_length, string_offset,
                  output ready);
endinterface

// ===== rtl/core/binary_json_scalar_decoder.sv =====
// top level of the binary json scalar decoder
//
// in_ch carries one record byte per transfer with last_byte marking the
// closing byte; the first byte of each record is its type code. out_ch
// carries one decoded result per record: kind, raw or extended value bits,
// string length and string data offset.
// each byte passes an input register, the decode logic and, on the closing
// byte, the result register, which drives out_ch.valid; a full result
// register can hold the closing byte in the input register. one byte is
// taken every cycle while no closing byte waits on a full result register.
// bytes without last_byte produce no result and need no room at the output.
// if the receiver stalls, the pending result holds in the output register;
// bytes keep flowing until a closing byte meets a full output register, then
// in_ch.ready drops once the input register is occupied too.
// a synchronous reset (rst_n low) empties both registers and returns the
// decoder to waiting for a type byte.
module binary_json_scalar_decoder
  import bjsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bjsd_in_if.sink    in_ch,
  bjsd_out_if.source out_ch
);

  in_item_t item;
  logic     item_valid;
  logic     item_take;
  result_t  res;
  logic     res_load;
  logic     out_space;

  bjsd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  bjsd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .out_space  (out_space),
    .res        (res),
    .res_load   (res_load)
  );

  bjsd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_load  (res_load),
    .out_space (out_space),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/core/bjsd_in_stage.sv =====
// input register stage holding one byte ahead of the decoder
module bjsd_in_stage
  import bjsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  bjsd_in_if.sink  in_ch,
  output in_item_t item,
  output logic     item_valid,
  input  logic     item_take
);

  logic     valid_r;
  in_item_t item_r;

  assign in_ch.ready = !valid_r || item_take;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

endmodule

// ===== rtl/core/bjsd_decode.sv =====
// record state and per-byte decode, producing a result on the closing byte
module bjsd_decode
  import bjsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  logic     item_valid,
  output logic     item_take,
  input  logic     out_space,
  output result_t  res,
  output logic     res_load
);

  localparam logic [1:0] PH_TYPE   = 2'd0;
  localparam logic [1:0] PH_FIXED  = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  localparam logic [32:0] COUNT_MAX = '1;

  logic [1:0]  phase_r,  phase_nxt;
  logic [3:0]  type_r,   type_nxt;
  logic [32:0] cnt_r,    cnt_nxt;
  logic [63:0] vacc_r,   vacc_nxt;
  logic [34:0] lacc_r,   lacc_nxt;
  logic [2:0]  lcnt_r,   lcnt_nxt;
  logic        err_r,    err_nxt;

  logic [7:0]  b;
  logic [35:0] str_need;
  logic        short8;

  assign b         = item.data_byte;
  assign item_take = item_valid && (!item.last_byte || out_space);
  assign res_load  = item_take && item.last_byte;

  // state update for one byte
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    cnt_nxt   = cnt_r;
    vacc_nxt  = vacc_r;
    lacc_nxt  = lacc_r;
    lcnt_nxt  = lcnt_r;
    err_nxt   = err_r;
    if (phase_r == PH_TYPE) begin
      type_nxt  = b[3:0];
      err_nxt   = !((b >= {4'h0, TC_LITERAL}) && (b <= {4'h0, TC_STRING}));
      phase_nxt = (b == {4'h0, TC_STRING}) ? PH_PREFIX : PH_FIXED;
      cnt_nxt   = '0;
      vacc_nxt  = '0;
      lacc_nxt  = '0;
      lcnt_nxt  = '0;
    end else begin
      // only the first eight payload bytes land in the value
      if (cnt_r[32:3] == '0) begin
        for (int i = 0; i < 8; i++) begin
          if (cnt_r[2:0] == 3'(i)) vacc_nxt[8*i +: 8] = vacc_r[8*i +: 8] | b;
        end
      end
      if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + 33'd1;
      if (phase_r == PH_PREFIX && lcnt_r < 3'(PREFIX_MAX_BYTES)) begin
        for (int i = 0; i < PREFIX_MAX_BYTES; i++) begin
          if (lcnt_r == 3'(i)) lacc_nxt[7*i +: 7] = lacc_r[7*i +: 7] | b[6:0];
        end
        lcnt_nxt = lcnt_r + 3'd1;
        if (!b[7]) begin
          if (lacc_nxt[34:32] != '0) err_nxt = 1'b1;
          phase_nxt = PH_BODY;
        end else if (lcnt_nxt == 3'(PREFIX_MAX_BYTES)) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_BODY;
        end
      end
    end
  end

  assign str_need = {33'd0, lcnt_nxt} + {1'b0, lacc_nxt};
  assign short8   = (cnt_nxt < 33'd8);

  // result of a record closing on this byte
  always_comb begin
    res = '{value_kind: KIND_ERROR, value_bits: '0, string_length: '0, string_offset: '0};
    if (!err_nxt && phase_nxt != PH_TYPE) begin
      unique case (type_nxt) inside
        TC_LITERAL: begin
          if (cnt_nxt != '0 && vacc_nxt[7:0] <= LIT_FALSE)
            res.value_kind = vacc_nxt[2:0];
        end
        TC_INT16: begin
          if (cnt_nxt >= 33'd2) begin
            res.value_kind = KIND_SINT;
            res.value_bits = {{48{vacc_nxt[15]}}, vacc_nxt[15:0]};
          end
        end
        TC_UINT16: begin
          if (cnt_nxt >= 33'd2) begin
            res.value_kind = KIND_UINT;
            res.value_bits = {48'd0, vacc_nxt[15:0]};
          end
        end
        TC_INT32: begin
          if (cnt_nxt >= 33'd4) begin
            res.value_kind = KIND_SINT;
            res.value_bits = {{32{vacc_nxt[31]}}, vacc_nxt[31:0]};
          end
        end
        TC_UINT32: begin
          if (cnt_nxt >= 33'd4) begin
            res.value_kind = KIND_UINT;
            res.value_bits = {32'd0, vacc_nxt[31:0]};
          end
        end
        TC_INT64, TC_UINT64, TC_DOUBLE: begin
          if (!short8) begin
            res.value_bits = vacc_nxt;
            if (type_nxt == TC_INT64)       res.value_kind = KIND_SINT;
            else if (type_nxt == TC_UINT64) res.value_kind = KIND_UINT;
            else                            res.value_kind = KIND_DOUBLE;
          end
        end
        TC_STRING: begin
          if (phase_nxt == PH_BODY && {3'd0, cnt_nxt} >= str_need) begin
            res.value_kind    = KIND_STRING;
            res.string_length = lacc_nxt[31:0];
            res.string_offset = lcnt_nxt + 3'd1;
          end
        end
        default: res.value_kind = KIND_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= '0;
      cnt_r   <= '0;
      vacc_r  <= '0;
      lacc_r  <= '0;
      lcnt_r  <= '0;
      err_r   <= 1'b0;
    end else if (item_take) begin
      if (item.last_byte) begin
        // record closed, back to waiting for a type byte
        phase_r <= PH_TYPE;
        type_r  <= '0;
        cnt_r   <= '0;
        vacc_r  <= '0;
        lacc_r  <= '0;
        lcnt_r  <= '0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        type_r  <= type_nxt;
        cnt_r   <= cnt_nxt;
        vacc_r  <= vacc_nxt;
        lacc_r  <= lacc_nxt;
        lcnt_r  <= lcnt_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/bjsd_out_stage.sv =====
// result register driving the output channel
module bjsd_out_stage
  import bjsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  result_t   res,
  input  logic      res_load,
  output logic      out_space,
  bjsd_out_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  assign out_space            = !valid_r || out_ch.ready;
  assign out_ch.valid         = valid_r;
  assign out_ch.value_kind    = res_r.value_kind;
  assign out_ch.value_bits    = res_r.value_bits;
  assign out_ch.string_length = res_r.string_length;
  assign out_ch.string_offset = res_r.string_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_space) begin
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the binary json scalar decoder
`timescale 1ns / 100ps

module tb;
  import bjsd_pkg::*;

  localparam logic [7:0] LIT_TRUE_BYTE = 8'h01;
  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {WAIT_TYPE, FIXED_BODY, LEN_PREFIX, STR_BODY} decode_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } stim_t;

  logic clk;
  logic rst_n;

  bjsd_in_if  in_ch();
  bjsd_out_if out_ch();

  binary_json_scalar_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_t       pending_bytes[$];
  logic [7:0]  rec[$];
  result_t     expected_results[$];
  int unsigned mismatch_count;
  int unsigned bytes_queued;
  int unsigned idle_cycles;

  // predictor state
  decode_phase_t dph;
  logic [3:0]    tcode;
  logic [32:0]   pcount;
  logic [63:0]   vacc;
  logic [34:0]   lacc;
  logic [2:0]    lbc;
  logic          rerr;

  // sender and receiver pacing
  int  gap_left;
  int  burst_left;
  bit  draining;
  int  stall_cycle;
  int  stall_mode;

  task automatic clear_decoder();
    dph = WAIT_TYPE;
    tcode = '0;
    pcount = '0;
    vacc = '0;
    lacc = '0;
    lbc = '0;
    rerr = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last, output bit emit,
                             output result_t res);
    res = '0;
    res.value_kind = KIND_ERROR;
    if (dph == WAIT_TYPE) begin
      tcode = b[3:0];
      rerr = !(b >= {4'h0, TC_LITERAL} && b <= {4'h0, TC_STRING});
      dph = (b == {4'h0, TC_STRING}) ? LEN_PREFIX : FIXED_BODY;
      pcount = '0;
      vacc = '0;
      lacc = '0;
      lbc = '0;
    end else begin
      if (pcount < 33'd8) vacc = vacc | (64'(b) << {pcount[2:0], 3'b000});
      if (pcount != {33{1'b1}}) pcount = pcount + 33'd1;
      if (dph == LEN_PREFIX && lbc < PREFIX_MAX_BYTES) begin
        lacc = lacc | (35'(b[6:0]) << (7 * lbc));
        lbc = lbc + 3'd1;
        if (!b[7]) begin
          if (lacc > 35'h0_FFFF_FFFF) rerr = 1'b1;
          dph = STR_BODY;
        end else if (lbc == PREFIX_MAX_BYTES) begin
          rerr = 1'b1;
          dph = STR_BODY;
        end
      end
    end
    emit = last;
    if (last) begin
      if (!rerr) begin
        case (tcode)
          TC_LITERAL: begin
            if (pcount >= 33'd1) begin
              case (vacc[7:0])
                LIT_NULL:      res.value_kind = KIND_NULL;
                LIT_TRUE_BYTE: res.value_kind = KIND_TRUE;
                LIT_FALSE:     res.value_kind = KIND_FALSE;
                default:       res.value_kind = KIND_ERROR;
              endcase
            end
          end
          TC_INT16: if (pcount >= 33'd2) begin
            res.value_kind = KIND_SINT;
            res.value_bits = {{48{vacc[15]}}, vacc[15:0]};
          end
          TC_UINT16: if (pcount >= 33'd2) begin
            res.value_kind = KIND_UINT;
            res.value_bits = {48'h0, vacc[15:0]};
          end
          TC_INT32: if (pcount >= 33'd4) begin
            res.value_kind = KIND_SINT;
            res.value_bits = {{32{vacc[31]}}, vacc[31:0]};
          end
          TC_UINT32: if (pcount >= 33'd4) begin
            res.value_kind = KIND_UINT;
            res.value_bits = {32'h0, vacc[31:0]};
          end
          TC_INT64: if (pcount >= 33'd8) begin
            res.value_kind = KIND_SINT;
            res.value_bits = vacc;
          end
          TC_UINT64: if (pcount >= 33'd8) begin
            res.value_kind = KIND_UINT;
            res.value_bits = vacc;
          end
          TC_DOUBLE: if (pcount >= 33'd8) begin
            res.value_kind = KIND_DOUBLE;
            res.value_bits = vacc;
          end
          TC_STRING: begin
            // body must hold prefix plus declared length
            if (dph == STR_BODY && {3'b000, pcount} >= {33'h0, lbc} + {1'b0, lacc}) begin
              res.value_kind = KIND_STRING;
              res.string_length = lacc[31:0];
              res.string_offset = lbc + 3'd1;
            end
          end
          default: res.value_kind = KIND_ERROR;
        endcase
      end
      clear_decoder();
    end
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch in %s: expected %h, got %h", field, exp_v, got_v);
  endtask

  // stimulus building

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_record();
    for (int i = 0; i < rec.size(); i++) begin
      pending_bytes.push_back('{data: rec[i], last: (i == rec.size() - 1), hold: 1'b0});
    end
    bytes_queued += rec.size();
    rec.delete();
  endtask

  task automatic send_pause();
    pending_bytes.push_back('{data: 8'h00, last: 1'b0, hold: 1'b1});
  endtask

  // bytes are given first byte leftmost
  task automatic queue_record(input int n, input logic [127:0] bytes);
    for (int i = 0; i < n; i++) rec.push_back(bytes[8 * (n - 1 - i) +: 8]);
    send_record();
  endtask

  // pad adds redundant continuation groups, capped at five groups
  task automatic add_prefix(input logic [34:0] len, input int pad);
    int n_min;
    int total;
    logic [34:0] sh;
    n_min = 1;
    while (n_min < 5 && (len >> (7 * n_min)) != 0) n_min++;
    total = n_min + pad;
    if (total > 5) total = 5;
    for (int i = 0; i < total; i++) begin
      sh = len >> (7 * i);
      rec.push_back({(i < total - 1) ? 1'b1 : 1'b0, sh[6:0]});
    end
  endtask

  task automatic build_good_record();
    logic [3:0] tc;
    int n;
    tc = 4'($urandom_range(TC_LITERAL, TC_STRING));
    rec.push_back({4'h0, tc});
    case (tc)
      TC_LITERAL: begin
        if ($urandom_range(0, 7) == 0) rec.push_back(rand_byte());
        else rec.push_back(8'($urandom_range(0, 2)));
      end
      TC_STRING: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 20);
        add_prefix(35'(n), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        repeat (n) rec.push_back(rand_byte());
      end
      default: begin
        case (tc) inside
          TC_INT16, TC_UINT16: n = 2;
          TC_INT32, TC_UINT32: n = 4;
          default:             n = 8;
        endcase
        repeat (n) rec.push_back(rand_byte());
      end
    endcase
    // trailing bytes past the payload are ignored by the decoder
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) rec.push_back(rand_byte());
  endtask

  task automatic build_broken_record();
    case ($urandom_range(0, 3))
      0: begin
        rec.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 10)) rec.push_back(rand_byte());
      end
      1: begin
        build_good_record();
        if (rec.size() > 1) repeat ($urandom_range(1, rec.size() - 1)) void'(rec.pop_back());
      end
      2: begin
        // continuation bit on all five prefix bytes
        rec.push_back({4'h0, TC_STRING});
        repeat (5) rec.push_back(8'($urandom_range(128, 255)));
        repeat ($urandom_range(0, 3)) rec.push_back(rand_byte());
      end
      default: begin
        // five-byte prefix, often beyond 32 bits
        rec.push_back({4'h0, TC_STRING});
        repeat (4) rec.push_back(8'($urandom_range(128, 255)));
        rec.push_back(8'($urandom_range(0, 127)));
        repeat ($urandom_range(0, 4)) rec.push_back(rand_byte());
      end
    endcase
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    bit send;
    stim_t nxt;
    send = 1'b0;
    nxt = '0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'h00;
      in_ch.last_byte <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 48);
      draining = 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 48);
        end
      end
      if (draining) begin
        if (expected_results.size() == 0) draining = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        if (nxt.hold) draining = 1'b1;
        else send = 1'b1;
      end
      in_ch.valid <= send;
      if (send) begin
        in_ch.data_byte <= nxt.data;
        in_ch.last_byte <= nxt.last;
      end
    end
  end

  // receiver stall pattern, switching style among four, picked anew at random
  always @(posedge clk) begin
    bit rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cycle = 0;
      stall_mode = 1;
    end else begin
      stall_cycle++;
      if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ((stall_cycle % 24) < 10);
      endcase
      out_ch.ready <= rdy;
    end
  end

  // monitor: check results, then predict from accepted bytes
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t predicted;
    bit emit;
    if (!rst_n) begin
      clear_decoder();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{value_kind: out_ch.value_kind, value_bits: out_ch.value_bits,
                string_length: out_ch.string_length, string_offset: out_ch.string_offset};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result with none expected: kind %0d bits %h len %0d off %0d",
                     got.value_kind, got.value_bits, got.string_length, got.string_offset);
        end else begin
          want = expected_results.pop_front();
          if (got.value_kind !== want.value_kind)
            note_mismatch("value_kind", 64'(want.value_kind), 64'(got.value_kind));
          if (got.value_bits !== want.value_bits)
            note_mismatch("value_bits", want.value_bits, got.value_bits);
          if (got.string_length !== want.string_length)
            note_mismatch("string_length", 64'(want.string_length), 64'(got.string_length));
          if (got.string_offset !== want.string_offset)
            note_mismatch("string_offset", 64'(want.string_offset), 64'(got.string_offset));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte, in_ch.last_byte, emit, predicted);
        if (emit) expected_results.push_back(predicted);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int records;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    bytes_queued = 0;

    // literals, good and bad
    queue_record(2, {8'h04, 8'h00});
    queue_record(2, {8'h04, 8'h01});
    queue_record(2, {8'h04, 8'h02});
    queue_record(2, {8'h04, 8'h03});
    queue_record(2, {8'h04, 8'hFF});
    // type byte with no payload
    queue_record(1, {8'h04});
    // integer and double extremes
    queue_record(3, {8'h05, 8'h00, 8'h80});
    queue_record(3, {8'h05, 8'hFF, 8'h7F});
    queue_record(3, {8'h06, 8'hFF, 8'hFF});
    queue_record(5, {8'h07, 8'h00, 8'h00, 8'h00, 8'h80});
    queue_record(5, {8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_record(9, {8'h09, 56'h0, 8'h80});
    queue_record(9, {8'h0A, {8{8'hFF}}});
    queue_record(9, {8'h0B, 64'h182D4454FB210940});
    // payload too short, and extra payload
    queue_record(3, {8'h07, 8'h01, 8'h02});
    queue_record(5, {8'h06, 8'h34, 8'h12, 8'h56, 8'h78});
    // strings: empty, with extra bytes, redundant prefix group
    queue_record(2, {8'h0C, 8'h00});
    queue_record(6, {8'h0C, 8'h03, 8'h61, 8'h62, 8'h63, 8'hEE});
    queue_record(5, {8'h0C, 8'h82, 8'h00, 8'h78, 8'h79});
    // string errors: prefix too long, length too large, body too short, cut in prefix
    queue_record(7, {8'h0C, {5{8'h80}}, 8'h41});
    queue_record(6, {8'h0C, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10});
    queue_record(7, {8'h0C, {4{8'hFF}}, 8'h0F, 8'h41});
    queue_record(4, {8'h0C, 8'h05, 8'h61, 8'h62});
    queue_record(2, {8'h0C, 8'h85});
    // unknown type codes
    queue_record(2, {8'h00, 8'h00});
    queue_record(3, {8'h0D, 8'h11, 8'h22});
    queue_record(2, {8'h14, 8'h00});
    queue_record(1, {8'hFF});
    send_pause();

    records = 0;
    while (bytes_queued < RANDOM_BYTES + 200) begin
      if ($urandom_range(0, 4) == 0) build_broken_record();
      else build_good_record();
      send_record();
      records++;
      if (records == 80) send_pause();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || draining || in_ch.valid ||
           expected_results.size() != 0)
      @(negedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
